// File: src/can_prof_pkg.sv
`default_nettype none
package can_prof_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // Record codes.
  localparam logic [3:0] REC_COUNTS = 4'd0;
  localparam logic [3:0] REC_TIMES  = 4'd1;
  localparam logic [3:0] REC_GSUM   = 4'd2;
  localparam logic [3:0] REC_LANE0  = 4'd3;
  localparam logic [3:0] REC_LAST   = 4'd10;

  // Saturation limits.
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [39:0] LSUM_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] can_id;
    logic        extended;
    logic        fd;
    logic        brs;
    logic        esi;
    logic [3:0]  dlc;
    logic [63:0] timestamp;
    logic [63:0] payload;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  record;
    logic        last;
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic [63:0] value_c;
    logic [63:0] value_d;
    logic [3:0]  max_dlc_seen;
    logic [3:0]  max_fd_dlc_seen;
    logic        id_extended;
  } result_t;

  // One profile entry as stored.
  typedef struct packed {
    logic        ext;
    logic [31:0] cnt_frames;
    logic [31:0] cnt_fd;
    logic [31:0] cnt_brs;
    logic [31:0] cnt_esi;
    logic [63:0] ts_first;
    logic [63:0] ts_last;
    logic [63:0] gap_min;
    logic [63:0] gap_max;
    logic [63:0] gap_sum;
    logic [3:0]  dlc_peak;
    logic [3:0]  fd_dlc_peak;
  } prof_t;

  // One byte lane of a profile.
  typedef struct packed {
    logic [7:0]  lmin;
    logic [7:0]  lmax;
    logic [39:0] lsum;
  } lane_t;

endpackage
`default_nettype wire

// File: src/can_id_traffic_profiler.sv
// Throughput: one request at a time; the identifier search reads the key
// memory one entry per cycle, and byte lanes go through one lane unit in turn.
// Reset clears the FSM, the entry valid bits and the total frame count.
`default_nettype none
module can_id_traffic_profiler #(
  parameter int ENTRIES    = 64,
  parameter int BYTE_LANES = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         item_valid,
  output logic                        item_stall,
  input  wire can_prof_pkg::item_t    item,
  output logic                        result_valid,
  input  wire                         result_stall,
  output can_prof_pkg::result_t       result
);

  localparam int CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PREAD, S_PLOAD, S_GAP, S_UPD, S_LRD, S_LUPD,
    S_WB, S_QREC, S_QLA, S_QLB, S_EMIT
  } state_t;

  state_t                state;
  can_prof_pkg::item_t   item_q;
  logic [ENTRIES-1:0]    valid;
  logic [31:0]           frames_total;
  logic [CW-1:0]         scan_idx;
  logic [CW-1:0]         cmp_idx;
  logic                  cmp_vld;
  logic                  free_found;
  logic [CW-1:0]         free_idx;
  logic [CW-1:0]         ent;
  logic                  is_new;
  logic [63:0]           gap;
  logic [2:0]            lane_idx;
  logic [3:0]            rec;
  can_prof_pkg::prof_t   prof_cur;
  can_prof_pkg::result_t pend;

  // Memories and their registered read data.
  logic [28:0]           key_mem  [ENTRIES];
  can_prof_pkg::prof_t   prof_mem [ENTRIES];
  can_prof_pkg::lane_t   lane_mem [ENTRIES*8];
  logic [28:0]           key_rd;
  can_prof_pkg::prof_t   prof_rd;
  can_prof_pkg::lane_t   lane_rd;

  logic                  accept;
  logic                  can_emit;
  logic                  hit;
  logic                  scan_end;
  logic                  key_we;
  logic                  prof_we;
  logic                  lane_we;
  logic [3:0]            n_bytes;
  logic                  lane_active;
  logic [7:0]            lane_byte;
  can_prof_pkg::lane_t   lane_base;
  can_prof_pkg::lane_t   lane_new;
  logic [40:0]           lsum_wide;
  logic [64:0]           gsum_wide;
  can_prof_pkg::prof_t   prof_upd;
  can_prof_pkg::prof_t   prof_init;
  can_prof_pkg::result_t pend_init;

  function automatic logic [31:0] inc32(input logic [31:0] v);
    inc32 = (v == can_prof_pkg::CNT_MAX) ? v : v + 32'd1;
  endfunction

  assign accept   = item_valid && !item_stall;
  assign can_emit = !result_valid || !result_stall;
  assign hit      = cmp_vld && valid[cmp_idx] && (key_rd == item_q.can_id);
  assign scan_end = cmp_vld && !hit && (cmp_idx == LAST_IDX);
  assign key_we   = (state == S_SCAN) && scan_end && free_found
                    && (item_q.kind == can_prof_pkg::KIND_FRAME);
  assign prof_we  = (state == S_WB);
  assign lane_we  = (state == S_LUPD);

  // Starting result of a request: final, all fields zero except a clear's status.
  always_comb begin
    pend_init      = '0;
    pend_init.last = 1'b1;
    if (item.kind == can_prof_pkg::KIND_CLEAR) pend_init.status = can_prof_pkg::ST_CLEARED;
  end

  // Profile of a newly created entry.
  always_comb begin
    prof_init          = '0;
    prof_init.ext      = item_q.extended;
    prof_init.ts_first = item_q.timestamp;
    prof_init.ts_last  = item_q.timestamp;
    prof_init.gap_min  = 64'hFFFF_FFFF_FFFF_FFFF;
  end

  // Byte lane update: one lane per pass through the shared unit.
  assign n_bytes     = (item_q.dlc > 4'd8) ? 4'd8 : item_q.dlc;
  assign lane_active = ({1'b0, lane_idx} < n_bytes) && (32'(lane_idx) < BYTE_LANES);
  assign lane_byte   = item_q.payload[8*lane_idx +: 8];

  always_comb begin
    if (is_new) begin
      lane_base.lmin = 8'hFF;
      lane_base.lmax = 8'h00;
      lane_base.lsum = 40'd0;
    end else begin
      lane_base = lane_rd;
    end
    lane_new  = lane_base;
    lsum_wide = {1'b0, lane_base.lsum} + {33'd0, lane_byte};
    if (lane_active) begin
      if (lane_byte < lane_base.lmin) lane_new.lmin = lane_byte;
      if (lane_byte > lane_base.lmax) lane_new.lmax = lane_byte;
      lane_new.lsum = lsum_wide[40] ? can_prof_pkg::LSUM_MAX : lsum_wide[39:0];
    end
  end

  // Profile update for a frame, using the interval registered in the step before.
  always_comb begin
    prof_upd  = prof_cur;
    gsum_wide = {1'b0, prof_cur.gap_sum} + {1'b0, gap};
    if (!is_new) begin
      if (gap < prof_cur.gap_min) prof_upd.gap_min = gap;
      if (gap > prof_cur.gap_max) prof_upd.gap_max = gap;
      prof_upd.gap_sum = gsum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : gsum_wide[63:0];
      prof_upd.ts_last = item_q.timestamp;
    end
    prof_upd.cnt_frames = inc32(prof_cur.cnt_frames);
    if (item_q.fd) begin
      prof_upd.cnt_fd = inc32(prof_cur.cnt_fd);
      if (item_q.brs) prof_upd.cnt_brs = inc32(prof_cur.cnt_brs);
      if (item_q.esi) prof_upd.cnt_esi = inc32(prof_cur.cnt_esi);
      if (item_q.dlc > prof_cur.fd_dlc_peak) prof_upd.fd_dlc_peak = item_q.dlc;
    end
    if (n_bytes > prof_cur.dlc_peak) prof_upd.dlc_peak = n_bytes;
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[free_idx] <= item_q.can_id;
    key_rd <= key_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (prof_we) prof_mem[ent] <= prof_cur;
    prof_rd <= prof_mem[ent];
  end

  always_ff @(posedge clk) begin
    if (lane_we) lane_mem[{ent, lane_idx}] <= lane_new;
    lane_rd <= lane_mem[{ent, lane_idx}];
  end

  assign item_stall = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      frames_total <= 32'd0;
      result_valid <= 1'b0;
      cmp_vld      <= 1'b0;
      free_found   <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_EMIT)) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_q     <= item;
            scan_idx   <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            pend       <= pend_init;
            unique case (item.kind)
              can_prof_pkg::KIND_FRAME: begin
                frames_total <= inc32(frames_total);
                state        <= S_SCAN;
              end
              can_prof_pkg::KIND_QUERY: state <= S_SCAN;
              can_prof_pkg::KIND_CLEAR: begin
                valid        <= '0;
                frames_total <= 32'd0;
                state        <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // Search the key memory one entry per cycle, noting the first free slot.
        S_SCAN: begin
          cmp_idx <= scan_idx;
          cmp_vld <= 1'b1;
          if (scan_idx != LAST_IDX) scan_idx <= scan_idx + CW'(1);
          if (!free_found && !valid[scan_idx]) begin
            free_found <= 1'b1;
            free_idx   <= scan_idx;
          end
          if (hit) begin
            ent    <= cmp_idx;
            is_new <= 1'b0;
            state  <= S_PREAD;
          end else if (scan_end) begin
            if (item_q.kind == can_prof_pkg::KIND_QUERY) begin
              pend.status <= can_prof_pkg::ST_MISS;
              state       <= S_EMIT;
            end else if (!free_found) begin
              pend.status <= can_prof_pkg::ST_FULL;
              state       <= S_EMIT;
            end else begin
              valid[free_idx] <= 1'b1;
              ent             <= free_idx;
              is_new          <= 1'b1;
              prof_cur        <= prof_init;
              state           <= S_UPD;
            end
          end
        end
        S_PREAD: state <= S_PLOAD;
        S_PLOAD: begin
          prof_cur <= prof_rd;
          rec      <= can_prof_pkg::REC_COUNTS;
          state    <= (item_q.kind == can_prof_pkg::KIND_QUERY) ? S_QREC : S_GAP;
        end
        // Interval since the last frame; a non-increasing timestamp counts as zero.
        S_GAP: begin
          gap   <= (item_q.timestamp > prof_cur.ts_last) ?
                   item_q.timestamp - prof_cur.ts_last : 64'd0;
          state <= S_UPD;
        end
        S_UPD: begin
          prof_cur <= prof_upd;
          lane_idx <= 3'd0;
          state    <= S_LRD;
        end
        S_LRD: state <= S_LUPD;
        S_LUPD: begin
          lane_idx <= lane_idx + 3'd1;
          state    <= (lane_idx == 3'd7) ? S_WB : S_LRD;
        end
        S_WB: begin
          pend.status          <= is_new ? can_prof_pkg::ST_CREATED : can_prof_pkg::ST_UPDATED;
          pend.record          <= can_prof_pkg::REC_COUNTS;
          pend.value_a         <= {32'd0, prof_cur.cnt_frames};
          pend.value_b         <= {32'd0, prof_cur.cnt_fd};
          pend.value_c         <= {32'd0, prof_cur.cnt_brs};
          pend.value_d         <= {32'd0, prof_cur.cnt_esi};
          pend.max_dlc_seen    <= prof_cur.dlc_peak;
          pend.max_fd_dlc_seen <= prof_cur.fd_dlc_peak;
          pend.id_extended     <= prof_cur.ext;
          state                <= S_EMIT;
        end
        // Query: build one record per pass.
        S_QREC: begin
          pend.status          <= can_prof_pkg::ST_UPDATED;
          pend.record          <= rec;
          pend.last            <= (rec == can_prof_pkg::REC_LAST);
          pend.max_dlc_seen    <= prof_cur.dlc_peak;
          pend.max_fd_dlc_seen <= prof_cur.fd_dlc_peak;
          pend.id_extended     <= prof_cur.ext;
          priority if (rec == can_prof_pkg::REC_COUNTS) begin
            pend.value_a <= {32'd0, prof_cur.cnt_frames};
            pend.value_b <= {32'd0, prof_cur.cnt_fd};
            pend.value_c <= {32'd0, prof_cur.cnt_brs};
            pend.value_d <= {32'd0, prof_cur.cnt_esi};
            state        <= S_EMIT;
          end else if (rec == can_prof_pkg::REC_TIMES) begin
            pend.value_a <= prof_cur.ts_first;
            pend.value_b <= prof_cur.ts_last;
            pend.value_c <= prof_cur.gap_min;
            pend.value_d <= prof_cur.gap_max;
            state        <= S_EMIT;
          end else if (rec == can_prof_pkg::REC_GSUM) begin
            pend.value_a <= prof_cur.gap_sum;
            pend.value_b <= {32'd0, frames_total};
            pend.value_c <= 64'd0;
            pend.value_d <= 64'd0;
            state        <= S_EMIT;
          end else begin
            lane_idx <= 3'(rec - can_prof_pkg::REC_LANE0);
            state    <= S_QLA;
          end
        end
        S_QLA: state <= S_QLB;
        S_QLB: begin
          pend.value_a <= {56'd0, lane_rd.lmin};
          pend.value_b <= {56'd0, lane_rd.lmax};
          pend.value_c <= {24'd0, lane_rd.lsum};
          pend.value_d <= 64'd0;
          state        <= S_EMIT;
        end
        // Hand the pending result to the output register.
        S_EMIT: begin
          if (can_emit) begin
            result       <= pend;
            result_valid <= 1'b1;
            if (pend.last) begin
              state <= S_IDLE;
            end else begin
              rec   <= rec + 4'd1;
              state <= S_QREC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A clear empties the total frame count.
  a_clear_total: assert property (@(posedge clk) disable iff (rst)
    (accept && item.kind == can_prof_pkg::KIND_CLEAR) |=> (frames_total == 32'd0))
    else $error("frame total not cleared");

  // A created entry reports only its count record, as the final result.
  a_created_rec: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == can_prof_pkg::ST_CREATED)
    |-> (result.last && result.record == can_prof_pkg::REC_COUNTS))
    else $error("created entry result malformed");

  // The last query record closes the request.
  a_last_rec: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.record == can_prof_pkg::REC_LAST) |-> result.last)
    else $error("last record without last flag");

  // No request is taken while a search is under way.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> item_stall)
    else $error("request taken during search");

endmodule
`default_nettype wire
